@@ hw/rtl/bffba_pkg.sv @@
// bffba_pkg: shared types and codes for the bitmap first-fit block allocator
// no dependencies; used by every module under hw/rtl except bffba_div

package bffba_pkg;

  localparam int WORD_BITS = 32;
  localparam int POS_W     = 5;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_RUN  = 2'd1,
    ST_ZERO    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  // register select bit of paddr (byte address 4*i)
  localparam logic REG_HEAP_BASE = 1'b0;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } scan_res_t;

  typedef struct packed {
    logic                 en;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] data;
  } map_wr_t;

endpackage

@@ hw/rtl/bffba_map_ram.sv @@
// bffba_map_ram: used/free map storage, one 32-bit word per row
// bit-masked write port, registered read port; uses bffba_pkg

module bffba_map_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [AW-1:0]                      rd_addr,
  output logic [bffba_pkg::WORD_BITS-1:0]    rd_data,
  input  logic [AW-1:0]                      wr_addr,
  input  bffba_pkg::map_wr_t                 wr
);

  logic [bffba_pkg::WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int b = 0; b < bffba_pkg::WORD_BITS; b++) begin
        if (wr.mask[b]) begin
          mem[wr_addr][b] <= wr.data[b];
        end
      end
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/bffba_div.sv @@
// bffba_div: divide by a fixed power-of-two divisor as a registered shift
// no package dependency; quotient is ready in the cycle after start

module bffba_div #(
  parameter int DIVISOR = 4096,
  parameter int DW      = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int SH = $clog2(DIVISOR);

  logic [DW-1:0] quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      quo  <= '0;
    end else begin
      done <= start;
      if (start) begin
        quo <= dividend >> SH;
      end
    end
  end

  assign quotient = quo;

endmodule

@@ hw/rtl/bffba_scan.sv @@
// bffba_scan: first-fit run search over one map word with carried run length
// uses bffba_pkg (scan_res_t, word geometry)

module bffba_scan #(
  parameter int  NUM_BLOCKS = 1024,
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1)
) (
  input  logic [bffba_pkg::WORD_BITS-1:0] used,
  input  logic [CNT_W-1:0]                carry,
  input  logic [CNT_W-1:0]                need,
  output bffba_pkg::scan_res_t            res,
  output logic [CNT_W-1:0]                carry_next
);

  localparam int WB    = bffba_pkg::WORD_BITS;
  localparam int POS_W = bffba_pkg::POS_W;
  localparam int CW    = ((CNT_W > POS_W + 1) ? CNT_W : POS_W + 1) + 1;
  localparam logic [WB-1:0] ONES = '1;

  logic [WB-1:0]    freeb;
  logic [WB-1:0]    hits;
  logic [WB-1:0]    iso;
  logic [WB-1:0]    rev;
  logic [WB-1:0]    iso_r;
  logic [WB-1:0]    hi_mask;
  logic [WB-1:0]    win;
  logic [CW-1:0]    need_w;
  logic [CW-1:0]    carry_w;
  logic [CW-1:0]    jp1;
  logic [CW-1:0]    top;
  logic [CW-1:0]    sum;
  logic [POS_W-1:0] lo;
  logic [POS_W-1:0] pos;

  always_comb begin
    freeb   = ~used;
    need_w  = CW'(need);
    carry_w = CW'(carry);
    hits    = '0;
    win     = '0;
    lo      = '0;
    hi_mask = '0;
    jp1     = '0;
    // run of need free blocks ending at bit j
    for (int j = 0; j < WB; j++) begin
      jp1     = CW'(j + 1);
      hi_mask = ONES >> (WB - 1 - j);
      if (need_w <= jp1) begin
        lo      = POS_W'(jp1 - need_w);
        win     = hi_mask & (ONES << lo);
        hits[j] = ((freeb & win) == win);
      end else begin
        hits[j] = ((freeb & hi_mask) == hi_mask) && (carry_w >= (need_w - jp1));
      end
    end

    // lowest end position wins
    iso = hits & (~hits + 1'b1);
    pos = '0;
    for (int j = 0; j < WB; j++) begin
      if (iso[j]) begin
        pos = pos | POS_W'(j);
      end
    end
    res.hit = |hits;
    res.pos = pos;

    // free bits at the top of the word continue into the next one
    for (int j = 0; j < WB; j++) begin
      rev[j] = used[WB - 1 - j];
    end
    iso_r = rev & (~rev + 1'b1);
    top   = '0;
    for (int j = 0; j < WB; j++) begin
      if (iso_r[j]) begin
        top = top | CW'(j);
      end
    end
    sum        = (used == '0) ? (carry_w + CW'(WB)) : top;
    carry_next = (sum > CW'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(sum);
  end

endmodule

@@ hw/rtl/bitmap_first_fit_block_allocator_core.sv @@
// bitmap_first_fit_block_allocator_core: top level, request sequencer and apb register
// depends on bffba_pkg, bffba_map_ram, bffba_div, bffba_scan
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  --------------------------------------
//  request   in         in_valid / in_stall    func, request_bytes, free_address
//  result    out        out_valid / out_stall  granted_address, status
//  config    in         apb psel/penable       paddr, pwdata (heap_base at 0)
//
//  allocate divides, scans one map word a cycle, multiplies, adds the heap base and
//  marks the run; free divides and clears one bit; clear sweeps every word
//  zero size, null free and the unused code go straight to done; oversized and
//  out-of-range free end after the divide; a clearing pass after reset holds in_stall
//  high; one transaction at a time; the result register lets the next request in
//  while an earlier result is still stalled on the output

module bitmap_first_fit_block_allocator_core #(
  parameter int NUM_BLOCKS  = 1024,
  // power of two
  parameter int BLOCK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] request_bytes,
  input  logic [31:0] free_address,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] granted_address,
  output logic [1:0]  status
);

  localparam int WB        = bffba_pkg::WORD_BITS;
  localparam int POS_W     = bffba_pkg::POS_W;
  localparam int WORDS     = (NUM_BLOCKS + WB - 1) / WB;
  localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W     = $clog2(NUM_BLOCKS);
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int DW        = 33;
  localparam int LAST_BITS = NUM_BLOCKS - (WORDS - 1) * WB;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
  localparam logic [WB-1:0]  ONES      = '1;
  localparam logic [WB-1:0]  LAST_MASK =
    (LAST_BITS == WB) ? ONES : ((WB'(1) << LAST_BITS) - WB'(1));
  localparam logic [DW-1:0]  ROUND_ADD = DW'(BLOCK_BYTES - 1);
  localparam logic [31:0]    BB32      = 32'(BLOCK_BYTES);

  typedef enum logic [9:0] {
    S_INIT  = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_DIV   = 10'b00_0000_0100,
    S_SCAN  = 10'b00_0000_1000,
    S_MULT  = 10'b00_0001_0000,
    S_ADD   = 10'b00_0010_0000,
    S_MARK  = 10'b00_0100_0000,
    S_FREE  = 10'b00_1000_0000,
    S_CLEAR = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t                 state;
  logic [31:0]            heap_base;
  logic                   is_alloc;
  logic [CNT_W-1:0]       need;
  logic [CNT_W-1:0]       carry;
  logic [WAW-1:0]         rd_word;
  logic                   rd_done;
  logic [WAW-1:0]         ev_word;
  logic                   ev_valid;
  logic [IDX_W-1:0]       start_blk;
  logic [WAW-1:0]         start_word;
  logic [POS_W-1:0]       start_pos;
  logic [WAW-1:0]         end_word;
  logic [POS_W-1:0]       end_pos;
  logic [WAW-1:0]         mark_word;
  logic [WAW-1:0]         sweep_word;
  logic [WAW-1:0]         free_word;
  logic [POS_W-1:0]       free_pos;
  logic [31:0]            prod;
  logic [31:0]            res_addr;
  bffba_pkg::status_t     res_status;

  logic                   accept_in;
  logic                   cfg_wr;
  logic                   rd_en;
  logic [WB-1:0]          rd_data;
  logic [WB-1:0]          word_used;
  logic [WAW-1:0]         wr_addr;
  bffba_pkg::map_wr_t     wr;
  bffba_pkg::scan_res_t   scan_res;
  logic [CNT_W-1:0]       carry_next;
  logic                   div_start;
  logic [DW-1:0]          div_dividend;
  logic                   div_done;
  logic [DW-1:0]          quot;
  logic [31:0]            hit_end;
  logic [31:0]            hit_start;
  logic [31:0]            free_blk;
  logic [IDX_W+31:0]      mul_full;
  logic [POS_W-1:0]       mark_lo;
  logic [POS_W-1:0]       mark_hi;
  logic [WB-1:0]          mark_mask;

  // apb register access, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bffba_pkg::REG_HEAP_BASE);
  assign prdata = (paddr[2] == bffba_pkg::REG_HEAP_BASE) ? heap_base : 32'd0;

  // one transaction in flight; requests only taken in idle
  assign in_stall  = (state != S_IDLE);
  assign accept_in = in_valid && !in_stall;

  // shared block-size shift: byte count rounded up for allocate, heap offset for free
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b0, request_bytes} + ROUND_ADD;
    if (accept_in) begin
      if (func == bffba_pkg::FN_ALLOC) begin
        div_start = (request_bytes != 32'd0);
      end else if (func == bffba_pkg::FN_FREE) begin
        div_start    = (free_address != 32'd0);
        div_dividend = {1'b0, free_address - heap_base};
      end
    end
  end

  bffba_div #(
    .DIVISOR (BLOCK_BYTES),
    .DW      (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (quot)
  );

  // scan reads one word a cycle until the last word has been issued
  assign rd_en = (state == S_SCAN) && !rd_done;

  bffba_map_ram #(
    .DEPTH (WORDS),
    .AW    (WAW)
  ) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_word),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

  // bits past the last block read as used
  assign word_used = rd_data | ~((ev_word == LAST_WORD) ? LAST_MASK : ONES);

  bffba_scan #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_scan (
    .used       (word_used),
    .carry      (carry),
    .need       (need),
    .res        (scan_res),
    .carry_next (carry_next)
  );

  // run ends at the hit position, starts need - 1 blocks earlier
  assign hit_end   = (32'(ev_word) << POS_W) | 32'(scan_res.pos);
  assign hit_start = hit_end + 32'd1 - 32'(need);
  assign free_blk  = 32'(quot[IDX_W-1:0]);
  assign mul_full  = (IDX_W + 32)'(start_blk) * (IDX_W + 32)'(BB32);

  // word mask for marking: partial at the first and last word of the run
  always_comb begin
    mark_lo   = (mark_word == start_word) ? start_pos : '0;
    mark_hi   = (mark_word == end_word) ? end_pos : '1;
    mark_mask = (ONES << mark_lo) & (ONES >> (POS_W'(WB - 1) - mark_hi));
  end

  // map write port
  always_comb begin
    wr      = '0;
    wr_addr = sweep_word;
    unique case (state)
      S_INIT, S_CLEAR: begin
        wr.en   = 1'b1;
        wr.mask = ONES;
        wr.data = '0;
      end
      S_FREE: begin
        wr.en   = 1'b1;
        wr.mask = WB'(1) << free_pos;
        wr.data = '0;
        wr_addr = free_word;
      end
      S_MARK: begin
        wr.en   = 1'b1;
        wr.mask = mark_mask;
        wr.data = ONES;
        wr_addr = mark_word;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sweep_word <= '0;
      heap_base  <= 32'd0;
      out_valid  <= 1'b0;
      ev_valid   <= 1'b0;
      rd_done    <= 1'b0;
      is_alloc   <= 1'b0;
    end else begin
      ev_valid <= rd_en;
      ev_word  <= rd_word;
      if (cfg_wr) begin
        heap_base <= pwdata;
      end
      // output register: loaded from done, dropped once taken
      if ((state == S_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_INIT: begin
          // clearing pass after reset
          if (sweep_word == LAST_WORD) begin
            state <= S_IDLE;
          end else begin
            sweep_word <= sweep_word + 1'b1;
          end
        end

        S_IDLE: begin
          if (accept_in) begin
            res_addr <= 32'd0;
            unique case (bffba_pkg::func_t'(func))
              bffba_pkg::FN_ALLOC: begin
                is_alloc <= 1'b1;
                if (request_bytes == 32'd0) begin
                  res_status <= bffba_pkg::ST_ZERO;
                  state      <= S_DONE;
                end else begin
                  res_status <= bffba_pkg::ST_DONE;
                  state      <= S_DIV;
                end
              end
              bffba_pkg::FN_FREE: begin
                is_alloc <= 1'b0;
                if (free_address == 32'd0) begin
                  res_status <= bffba_pkg::ST_IGNORED;
                  state      <= S_DONE;
                end else begin
                  res_status <= bffba_pkg::ST_DONE;
                  state      <= S_DIV;
                end
              end
              bffba_pkg::FN_CLEAR: begin
                res_status <= bffba_pkg::ST_DONE;
                sweep_word <= '0;
                state      <= S_CLEAR;
              end
              bffba_pkg::FN_NONE: begin
                res_status <= bffba_pkg::ST_DONE;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_DIV: begin
          if (div_done) begin
            if (is_alloc) begin
              if (quot > DW'(NUM_BLOCKS)) begin
                res_status <= bffba_pkg::ST_NO_RUN;
                state      <= S_DONE;
              end else begin
                need    <= CNT_W'(quot);
                carry   <= '0;
                rd_word <= '0;
                rd_done <= 1'b0;
                state   <= S_SCAN;
              end
            end else begin
              if (quot >= DW'(NUM_BLOCKS)) begin
                res_status <= bffba_pkg::ST_IGNORED;
                state      <= S_DONE;
              end else begin
                free_word <= WAW'(free_blk >> POS_W);
                free_pos  <= POS_W'(free_blk);
                state     <= S_FREE;
              end
            end
          end
        end

        S_SCAN: begin
          if (rd_en) begin
            if (rd_word == LAST_WORD) begin
              rd_done <= 1'b1;
            end else begin
              rd_word <= rd_word + 1'b1;
            end
          end
          if (ev_valid) begin
            carry <= carry_next;
            if (scan_res.hit) begin
              start_blk  <= IDX_W'(hit_start);
              start_word <= WAW'(hit_start >> POS_W);
              start_pos  <= POS_W'(hit_start);
              end_word   <= ev_word;
              end_pos    <= scan_res.pos;
              state      <= S_MULT;
            end else if (ev_word == LAST_WORD) begin
              res_status <= bffba_pkg::ST_NO_RUN;
              state      <= S_DONE;
            end
          end
        end

        S_MULT: begin
          prod      <= mul_full[31:0];
          mark_word <= start_word;
          state     <= S_ADD;
        end

        S_ADD: begin
          res_addr <= heap_base + prod;
          state    <= S_MARK;
        end

        S_MARK: begin
          if (mark_word == end_word) begin
            state <= S_DONE;
          end else begin
            mark_word <= mark_word + 1'b1;
          end
        end

        S_FREE: begin
          state <= S_DONE;
        end

        S_CLEAR: begin
          if (sweep_word == LAST_WORD) begin
            state <= S_DONE;
          end else begin
            sweep_word <= sweep_word + 1'b1;
          end
        end

        S_DONE: begin
          // hand the result to the output register once it is free
          if (!out_valid || !out_stall) begin
            granted_address <= res_addr;
            status          <= res_status;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !wr.en)
    else $error("map written during scan");

  a_mark_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (mark_word <= end_word))
    else $error("marking past end of run");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

  a_fail_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != bffba_pkg::ST_DONE)) |-> (granted_address == 32'd0))
    else $error("non-zero address on failed request");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_valid && out_stall) |=> (state == S_DONE))
    else $error("result dropped while output stalled");
`endif

endmodule

@@ tb/sv/bitmap_first_fit_block_allocator_checker.sv @@
// bitmap_first_fit_block_allocator_checker: follows the apb, request and result channels
// keeps its own block map and heap base and checks every result; depends on bffba_pkg
`timescale 1ns / 1ps

module bitmap_first_fit_block_allocator_checker #(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] request_bytes,
  input  logic [31:0] free_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] granted_address,
  input  logic [1:0]  status,
  output int          mismatches,
  output int          outstanding,
  output int          results_checked
);

  localparam logic [2:0] HEAP_BASE_ADDR = 3'd0;

  typedef struct packed {
    logic [31:0]        addr;
    bffba_pkg::status_t st;
  } grant_t;

  logic        block_taken [NUM_BLOCKS];
  logic [31:0] base_shadow;
  grant_t      grants_due [$];

  // first-fit claim, single-block release or full clear on the local map
  function automatic grant_t predict_request(bffba_pkg::func_t fn, logic [31:0] bytes,
                                             logic [31:0] addr);
    grant_t      g;
    logic [63:0] need;
    int          run_start;
    int          run_len;
    bit          found;
    logic [31:0] offs;
    logic [31:0] blk;
    g.addr    = '0;
    g.st      = bffba_pkg::ST_DONE;
    found     = 1'b0;
    run_start = 0;
    run_len   = 0;
    case (fn)
      bffba_pkg::FN_ALLOC: begin
        need = ({32'd0, bytes} + 64'(BLOCK_BYTES - 1)) / 64'(BLOCK_BYTES);
        if (bytes == '0) begin
          g.st = bffba_pkg::ST_ZERO;
        end else begin
          if (need <= 64'(NUM_BLOCKS)) begin
            for (int i = 0; i < NUM_BLOCKS && !found; i++) begin
              if (block_taken[i]) begin
                run_len = 0;
              end else begin
                if (run_len == 0) run_start = i;
                run_len++;
                if (64'(run_len) == need) found = 1'b1;
              end
            end
          end
          if (found) begin
            for (int i = run_start; i < run_start + run_len; i++) block_taken[i] = 1'b1;
            g.addr = base_shadow + 32'(run_start) * 32'(BLOCK_BYTES);
          end else begin
            g.st = bffba_pkg::ST_NO_RUN;
          end
        end
      end
      bffba_pkg::FN_FREE: begin
        offs = addr - base_shadow;
        blk  = offs / 32'(BLOCK_BYTES);
        if (addr == '0 || blk >= 32'(NUM_BLOCKS)) begin
          g.st = bffba_pkg::ST_IGNORED;
        end else begin
          block_taken[blk] = 1'b0;
        end
      end
      bffba_pkg::FN_CLEAR: begin
        foreach (block_taken[i]) block_taken[i] = 1'b0;
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  always @(posedge clk) begin : follow
    grant_t want;
    if (rst) begin
      foreach (block_taken[i]) block_taken[i] = 1'b0;
      base_shadow = '0;
      grants_due.delete();
      mismatches      = 0;
      results_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == HEAP_BASE_ADDR)
        base_shadow = pwdata;
      if (in_valid && !in_stall)
        grants_due.push_back(predict_request(bffba_pkg::func_t'(func), request_bytes,
                                             free_address));
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          $error("result with nothing outstanding: granted_address %h status %0d",
                 granted_address, status);
          mismatches++;
        end else begin
          want = grants_due.pop_front();
          if (granted_address !== want.addr) begin
            $error("granted_address mismatch: expected %h, actual %h",
                   want.addr, granted_address);
            mismatches++;
          end
          if (status !== want.st) begin
            $error("status mismatch: expected %0d, actual %0d", want.st, status);
            mismatches++;
          end
          results_checked++;
        end
      end
    end
    outstanding = grants_due.size();
  end

endmodule

@@ tb/sv/bitmap_first_fit_block_allocator_core_tb.sv @@
// bitmap_first_fit_block_allocator_core_tb: stimulus, idling and verdict for the allocator
// depends on bffba_pkg, the allocator rtl and bitmap_first_fit_block_allocator_checker
`timescale 1ns / 1ps

module bitmap_first_fit_block_allocator_core_tb;

  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 4096;
  localparam logic [2:0] HEAP_BASE_ADDR = 3'd0;

  // random phases, one heap base each; 1860 random transactions in all
  localparam int BASE_PHASES     = 6;
  localparam int REQS_PER_PHASE  = 310;
  // worst transaction is a full-map scan plus marking, plus the
  // longest stall and the longest sender gap; the limit is many times that
  localparam int IDLE_LIMIT      = 4000;
  // settle time after the last result, to catch stray outputs
  localparam int SETTLE_CYCLES   = 150;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  func          = '0;
  logic [31:0] request_bytes = '0;
  logic [31:0] free_address  = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [31:0] granted_address;
  logic [1:0]  status;

  int          mismatches;
  int          outstanding;
  int          results_checked;

  logic [31:0] cur_base      = '0;
  int          reqs_sent     = 0;
  int          base_settings = 0;
  bit          calm          = 1'b0;
  int          calm_left     = 0;
  int          stall_hold    = 0;
  int          stuck_cycles  = 0;

  bitmap_first_fit_block_allocator_core #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .request_bytes  (request_bytes),
    .free_address   (free_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted_address(granted_address),
    .status         (status)
  );

  // scoreboard sits beside the block and sees exactly what it sees
  bitmap_first_fit_block_allocator_checker #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .request_bytes  (request_bytes),
    .free_address   (free_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted_address(granted_address),
    .status         (status),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_checked(results_checked)
  );

  always #1 clk = ~clk;

  // calm stretches: neither side idles nor stalls for a while
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(100, 400);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // result-side back-pressure: held for a random number of cycles, mostly short
  always @(posedge clk) begin : stall_gen
    int pick;
    pick = $urandom_range(0, 99);
    if (rst) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (calm) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (pick < 60) begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 7);
    end else if (pick < 95) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 2);
    end else begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(10, 40);
    end
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", stuck_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // sender gap after a transaction: mostly none, sometimes a few, rarely long
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm) return 0;
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // apb write: setup cycle, then access until pready
  task automatic write_heap_base(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HEAP_BASE_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    cur_base  = value;
    base_settings++;
    @(posedge clk);
  endtask

  // one request transaction; payload is held while stalled
  task automatic send_request(input bffba_pkg::func_t fn, input logic [31:0] bytes,
                              input logic [31:0] addr);
    int gap;
    in_valid      <= 1'b1;
    func          <= fn;
    request_bytes <= bytes;
    free_address  <= addr;
    do begin
      @(posedge clk);
    end while (in_stall);
    reqs_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block is idle once every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // sizes: mostly a few blocks, some exact multiples, a few huge or odd
  function automatic logic [31:0] alloc_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return $urandom_range(1, 4 * BLOCK_BYTES);
    if (pick < 70) return $urandom_range(1, 32 * BLOCK_BYTES);
    if (pick < 78) return $urandom_range(1, 64) * BLOCK_BYTES;
    if (pick < 84) return $urandom_range(32 * BLOCK_BYTES, (NUM_BLOCKS + 1) * BLOCK_BYTES);
    if (pick < 90) return $urandom();
    if (pick < 94) return 32'd0;
    return $urandom() | 32'h8000_0000;
  endfunction

  // free targets: mostly the low blocks first-fit fills, sometimes inner bytes
  function automatic logic [31:0] free_target();
    logic [31:0] blk;
    logic [31:0] offs;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) blk = $urandom_range(0, 127);
    else if (pick < 95) blk = $urandom_range(0, NUM_BLOCKS - 1);
    else blk = $urandom_range(NUM_BLOCKS, NUM_BLOCKS + 16);
    offs = ($urandom_range(0, 9) < 6) ? 32'd0 : 32'($urandom_range(0, BLOCK_BYTES - 1));
    return cur_base + blk * 32'(BLOCK_BYTES) + offs;
  endfunction

  // random mix: allocations outpace frees so the map fills and runs fail,
  // rare clears empty it again; unused fields carry noise
  task automatic random_request();
    bffba_pkg::func_t fn;
    logic [31:0]      bytes;
    logic [31:0]      addr;
    int               pick;
    pick  = $urandom_range(0, 99);
    bytes = $urandom();
    addr  = $urandom();
    if (pick < 55) begin
      fn    = bffba_pkg::FN_ALLOC;
      bytes = alloc_size();
    end else if (pick < 90) begin
      fn   = bffba_pkg::FN_FREE;
      addr = free_target();
    end else if (pick < 92) begin
      fn = bffba_pkg::FN_CLEAR;
    end else if (pick < 95) begin
      fn = bffba_pkg::FN_NONE;
    end else begin
      // null, wild and just-below-base frees
      fn = bffba_pkg::FN_FREE;
      case ($urandom_range(0, 3))
        0:       addr = 32'd0;
        1:       addr = cur_base - 32'($urandom_range(1, 2 * BLOCK_BYTES));
        default: addr = $urandom();
      endcase
    end
    send_request(fn, bytes, addr);
  endtask

  initial begin : stimulus
    logic [31:0] base;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part, heap base away from zero
    write_heap_base(32'h0010_0000);
    base = cur_base;
    // zero size, one byte in block 0, exact block 1, rounding up into blocks 2-3
    send_request(bffba_pkg::FN_ALLOC, 32'd0, 32'd0);
    send_request(bffba_pkg::FN_ALLOC, 32'd1, 32'hFFFF_FFFF);
    send_request(bffba_pkg::FN_ALLOC, 32'(BLOCK_BYTES), 32'd0);
    send_request(bffba_pkg::FN_ALLOC, 32'(BLOCK_BYTES + 1), 32'd0);
    // oversized
    send_request(bffba_pkg::FN_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_request(bffba_pkg::FN_ALLOC, 32'(NUM_BLOCKS * BLOCK_BYTES + 1), 32'd0);
    // null free, below base wrapping high, past the end, inner address
    send_request(bffba_pkg::FN_FREE, 32'd0, 32'd0);
    send_request(bffba_pkg::FN_FREE, 32'd0, base - 32'd1);
    send_request(bffba_pkg::FN_FREE, 32'd0, base + 32'(NUM_BLOCKS * BLOCK_BYTES));
    send_request(bffba_pkg::FN_FREE, 32'd0, base + 32'(2 * BLOCK_BYTES + 5));
    // reuses block 2 only, then a block that is already free
    send_request(bffba_pkg::FN_ALLOC, 32'd1, 32'd0);
    send_request(bffba_pkg::FN_FREE, 32'd0, base + 32'(500 * BLOCK_BYTES));
    // unused function
    send_request(bffba_pkg::FN_NONE, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
    send_request(bffba_pkg::FN_CLEAR, 32'd0, 32'd0);
    // whole map, then full map with no run, then the last block alone
    send_request(bffba_pkg::FN_ALLOC, 32'(NUM_BLOCKS * BLOCK_BYTES), 32'd0);
    send_request(bffba_pkg::FN_ALLOC, 32'd1, 32'd0);
    send_request(bffba_pkg::FN_FREE, 32'd0, base + 32'(NUM_BLOCKS * BLOCK_BYTES - 1));
    send_request(bffba_pkg::FN_ALLOC, 32'd1, 32'd0);
    send_request(bffba_pkg::FN_FREE, 32'd0, 32'hFFFF_FFFF);
    send_request(bffba_pkg::FN_CLEAR, 32'd0, 32'd0);
    send_request(bffba_pkg::FN_ALLOC, 32'h8000_0000, 32'd0);
    wait_idle();

    // granted address wrapping past the top of the address space
    write_heap_base(32'hFFFF_F000);
    send_request(bffba_pkg::FN_ALLOC, 32'(BLOCK_BYTES), 32'd0); // top page
    send_request(bffba_pkg::FN_ALLOC, 32'(BLOCK_BYTES), 32'd0); // wraps to zero
    send_request(bffba_pkg::FN_FREE, 32'd0, 32'd5);             // wrapped block 1
    send_request(bffba_pkg::FN_ALLOC, 32'd1, 32'd0);
    wait_idle();

    // random phases, each under its own heap base, extremes among them
    for (int p = 0; p < BASE_PHASES; p++) begin
      case (p)
        0:       base = 32'h0000_0000;
        1:       base = 32'hFFFF_FFFF;
        2:       base = 32'hFFC0_0000;
        3:       base = $urandom();
        4:       base = 32'h8000_0000;
        default: base = $urandom() & 32'hFFFF_F000;
      endcase
      write_heap_base(base);
      for (int n = 0; n < REQS_PER_PHASE; n++) random_request();
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d allocate/free/clear requests under %0d heap bases, %0d results checked",
             reqs_sent, base_settings, results_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
